// ===== sv/tmcd_pkg.sv =====
// Shared types, widths and codes for the trimmed-mean change detector.
package tmcd_pkg;

    localparam int SMP_W          = 24;
    localparam int AVG_W          = 25;
    localparam int THR_W          = 24;
    localparam int REQ_W          = 2;
    localparam int RING_DEPTH_DEF = 8;

    localparam int SMP_MAX    = 8388607;
    localparam int SMP_MIN    = -8388608;
    localparam int AVG_MAX    = 16777215;
    localparam int AVG_MIN    = -16777216;
    localparam int THR_RESET  = 1000;

    typedef logic signed [SMP_W-1:0] smp_t;
    typedef logic signed [AVG_W-1:0] avg_t;
    typedef logic [THR_W-1:0]        thr_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_OFFSET = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Control from the sequencer to the sum/extremes unit
    typedef struct packed {
        logic clear;   // load sum with minus offset, reset extremes
        logic acc_en;  // take one sample off the ring tail
        logic trim;    // form sum minus largest and smallest
    } accum_ctl_t;

endpackage

// ===== sv/trimmed_mean_change_detector.sv =====
// Top level of the trimmed moving-average change detector.
//
// Input words arrive on the s_ group: s_tuser carries the request kind
// (push sample, store offset, query average), s_tdata the signed 24-bit
// reading. Pushes and offset writes are taken one per cycle while idle and
// give no output word. A query gives one output word on the m_ group.
// A query with no new samples goes straight to the output state, which loads
// the output register once it is free. A query after new samples walks the
// ring: the cells rotate one place a cycle until each has passed the tail
// while the accumulator gathers sum, maximum and minimum; then the states
// trim, start the divider, wait for the reciprocal multiply, clamp, compare
// and load the output register, after which the block is idle again.
// One item is worked on at a time; s_tready is high only while idle.
// A stalled receiver (m_tready low) holds the output word, and the block
// still takes new input words; a further query waits until it is taken.
// Reset clears the ring to zeros, the write position, flags, offset and the
// last two averages, and loads the change threshold with 1000. cfg_wr_en
// writes the threshold; write it only while the block is idle.
module trimmed_mean_change_detector #(
    parameter int RING_DEPTH = tmcd_pkg::RING_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,   // [23:0] sample_value
    input  logic [1:0]              s_tuser,   // [1:0] req_type
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,   // [24:0] average_value,
                                               // [25] change_detected,
                                               // [26] buffer_filled, rest zero
    input  logic                    cfg_wr_en,
    input  tmcd_pkg::thr_t          cfg_wr_data
);
    import tmcd_pkg::*;

    localparam int NUM_W = $clog2(RING_DEPTH + 3) + 25;
    localparam int POS_W = $clog2(RING_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(RING_DEPTH - 1);
    localparam logic signed [NUM_W-1:0] AVG_HI = NUM_W'(AVG_MAX);
    localparam logic signed [NUM_W-1:0] AVG_LO = NUM_W'(AVG_MIN);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCAN   = 8'b0000_0010,
        ST_TRIM   = 8'b0000_0100,
        ST_DSTART = 8'b0000_1000,
        ST_DWAIT  = 8'b0001_0000,
        ST_CLAMP  = 8'b0010_0000,
        ST_CHECK  = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] wpos_reg, wpos_next;
    logic [POS_W-1:0] scan_reg, scan_next;
    logic             wrapped_reg, wrapped_next;
    logic             dirty_reg, dirty_next;
    logic             chg_reg, chg_next;
    smp_t             offset_reg, offset_next;
    thr_t             thr_reg, thr_next;
    avg_t             cur_reg, cur_next;
    avg_t             prev_reg, prev_next;
    avg_t             avg_reg, avg_next;
    logic             mvalid_reg, mvalid_next;
    logic [31:0]      mdata_reg, mdata_next;

    logic             in_acc;
    req_t             req;
    smp_t             smp;
    logic             push;
    logic             ring_en;
    smp_t             ring_head;
    smp_t             ring_q [RING_DEPTH];
    accum_ctl_t       acc_ctl;
    logic signed [NUM_W-1:0] trimmed;
    logic             div_done;
    logic signed [NUM_W-1:0] quot;
    logic signed [AVG_W:0]   d_cur;
    logic signed [AVG_W:0]   d_prev;
    logic [AVG_W:0]          a_cur;
    logic [AVG_W:0]          a_prev;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser);
    assign smp      = smp_t'(s_tdata);
    assign push     = in_acc && (req == REQ_PUSH);

    // Ring of cells: a push shifts the new sample in at the head, a scan
    // rotates the tail back round to the head. Order does not matter for
    // sum and extremes, so a shift line holds the same set as a ring buffer.
    assign ring_en   = push || (state_reg == ST_SCAN);
    assign ring_head = (state_reg == ST_SCAN) ? ring_q[RING_DEPTH-1] : smp;

    generate
        for (genvar i = 0; i < RING_DEPTH; i++)
        begin : g_ring
            if (i == 0)
            begin : g_head
                tmcd_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .en    (ring_en),
                    .d     (ring_head),
                    .q     (ring_q[i])
                );
            end
            else
            begin : g_body
                tmcd_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .en    (ring_en),
                    .d     (ring_q[i-1]),
                    .q     (ring_q[i])
                );
            end
        end
    endgenerate

    assign acc_ctl.clear  = in_acc && (req == REQ_QUERY) && dirty_reg;
    assign acc_ctl.acc_en = (state_reg == ST_SCAN);
    assign acc_ctl.trim   = (state_reg == ST_TRIM);

    tmcd_accum #(
        .NUM_W (NUM_W)
    ) u_accum (
        .clk     (clk),
        .ctl     (acc_ctl),
        .sample  (ring_q[RING_DEPTH-1]),
        .offset  (offset_reg),
        .trimmed (trimmed)
    );

    tmcd_div #(
        .NUM_W   (NUM_W),
        .DIVISOR (RING_DEPTH - 2)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DSTART),
        .num   (trimmed),
        .done  (div_done),
        .quot  (quot)
    );

    // Distances of the new average from the last two
    always_comb
    begin
        d_cur  = {avg_reg[AVG_W-1], avg_reg} - {cur_reg[AVG_W-1], cur_reg};
        d_prev = {avg_reg[AVG_W-1], avg_reg} - {prev_reg[AVG_W-1], prev_reg};
        a_cur  = d_cur[AVG_W]  ? ('0 - d_cur)  : d_cur;
        a_prev = d_prev[AVG_W] ? ('0 - d_prev) : d_prev;
    end

    always_comb
    begin
        state_next   = state_reg;
        wpos_next    = wpos_reg;
        scan_next    = scan_reg;
        wrapped_next = wrapped_reg;
        dirty_next   = dirty_reg;
        chg_next     = chg_reg;
        offset_next  = offset_reg;
        thr_next     = cfg_wr_en ? cfg_wr_data : thr_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        avg_next     = avg_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (req)
                        REQ_PUSH:
                        begin
                            dirty_next = 1'b1;
                            if (wpos_reg == POS_LAST)
                            begin
                                wpos_next    = '0;
                                wrapped_next = 1'b1;
                            end
                            else
                            begin
                                wpos_next = wpos_reg + 1'b1;
                            end
                        end
                        REQ_OFFSET:
                        begin
                            offset_next = smp;
                        end
                        REQ_QUERY:
                        begin
                            scan_next  = '0;
                            state_next = dirty_reg ? ST_SCAN : ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == POS_LAST)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                if (quot > AVG_HI)
                begin
                    avg_next = avg_t'(AVG_MAX);
                end
                else if (quot < AVG_LO)
                begin
                    avg_next = avg_t'(AVG_MIN);
                end
                else
                begin
                    avg_next = quot[AVG_W-1:0];
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // flag only when the jump is large against both older averages
                chg_next   = (a_cur > {2'b00, thr_reg}) && (a_prev > {1'b0, thr_reg, 1'b0});
                prev_next  = cur_reg;
                cur_next   = avg_reg;
                dirty_next = 1'b0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {5'b0, wrapped_reg, chg_reg, cur_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wpos_reg    <= '0;
            scan_reg    <= '0;
            wrapped_reg <= 1'b0;
            dirty_reg   <= 1'b0;
            chg_reg     <= 1'b0;
            offset_reg  <= '0;
            thr_reg     <= thr_t'(THR_RESET);
            cur_reg     <= '0;
            prev_reg    <= '0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            scan_reg    <= scan_next;
            wrapped_reg <= wrapped_next;
            dirty_reg   <= dirty_next;
            chg_reg     <= chg_next;
            offset_reg  <= offset_next;
            thr_reg     <= thr_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg   <= avg_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ===== sv/tmcd_cell.sv =====
// One ring cell: holds a sample and hands it on to its neighbour.
module tmcd_cell (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  tmcd_pkg::smp_t d,
    output tmcd_pkg::smp_t q
);
    import tmcd_pkg::*;

    smp_t data_reg;
    smp_t data_next;

    always_comb
    begin
        data_next = en ? d : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

// ===== sv/tmcd_accum.sv =====
// Running sum, largest and smallest sample over one pass of the ring.
module tmcd_accum #(
    parameter int NUM_W = 29
) (
    input  logic                     clk,
    input  tmcd_pkg::accum_ctl_t     ctl,
    input  tmcd_pkg::smp_t           sample,
    input  tmcd_pkg::smp_t           offset,
    output logic signed [NUM_W-1:0]  trimmed
);
    import tmcd_pkg::*;

    logic signed [NUM_W-1:0] sum_reg;
    logic signed [NUM_W-1:0] trim_reg;
    smp_t                    hi_reg;
    smp_t                    lo_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            // start from minus the offset so the trim needs no extra term
            sum_reg <= '0 - NUM_W'(offset);
            hi_reg  <= smp_t'(SMP_MIN);
            lo_reg  <= smp_t'(SMP_MAX);
        end
        else if (ctl.acc_en)
        begin
            sum_reg <= sum_reg + NUM_W'(sample);
            if (sample > hi_reg)
            begin
                hi_reg <= sample;
            end
            if (sample < lo_reg)
            begin
                lo_reg <= sample;
            end
        end
        if (ctl.trim)
        begin
            trim_reg <= sum_reg - NUM_W'(hi_reg) - NUM_W'(lo_reg);
        end
    end

    assign trimmed = trim_reg;

endmodule

// ===== sv/tmcd_div.sv =====
// Division by a fixed divisor through a reciprocal multiply, truncating toward zero.
module tmcd_div #(
    parameter int NUM_W   = 29,
    parameter int DIVISOR = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);
    // The numerator magnitude fits NUM_W-1 bits. With SHIFT = MAG_W + clog2(DIVISOR)
    // and the reciprocal rounded up, the product shifted down is the exact floor.
    localparam int MAG_W   = NUM_W - 1;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int SHIFT   = MAG_W + $clog2(DIVISOR);
    localparam longint RECIP_L =
        ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic [MAG_W-1:0]  mag_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              run_reg;
    logic              done_reg;

    logic [NUM_W-1:0]  num_abs;
    logic [PROD_W-1:0] prod_shr;
    logic [NUM_W-1:0]  quot_mag;

    always_comb
    begin
        num_abs  = num[NUM_W-1] ? ('0 - num) : num;
        prod_shr = prod_reg >> SHIFT;
        quot_mag = prod_shr[NUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= start;
            done_reg <= run_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // split off the sign, divide the magnitude
            mag_reg <= num_abs[MAG_W-1:0];
            neg_reg <= num[NUM_W-1];
        end
        if (run_reg)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP);
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? ('0 - quot_mag) : quot_mag;

endmodule
